### rtl/png_pixel_to_argb_converter_core_defines.svh
// Assertion macros for the PNG pixel to ARGB converter.
// Included by the top level; relies on clk and rst being in scope.
`ifndef PNG_PIXEL_TO_ARGB_CONVERTER_CORE_DEFINES_SVH
`define PNG_PIXEL_TO_ARGB_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define P2A_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter check failed (same cycle)");

// Next-cycle implication, checked at every rising edge outside reset.
`define P2A_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("converter check failed (next cycle)");

`endif

### rtl/p2argb_pkg.sv
// Shared constants, types and the format legality check for the converter.
// No dependencies.
package p2argb_pkg;

  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned CfgDataW = 9;

  // PNG colour type codes.
  localparam logic [2:0] CT_GRAY       = 3'd0;
  localparam logic [2:0] CT_RGB        = 3'd2;
  localparam logic [2:0] CT_PALETTE    = 3'd3;
  localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
  localparam logic [2:0] CT_RGBA       = 3'd6;

  // Bit depth codes.
  localparam logic [4:0] BD_1  = 5'd1;
  localparam logic [4:0] BD_2  = 5'd2;
  localparam logic [4:0] BD_4  = 5'd4;
  localparam logic [4:0] BD_8  = 5'd8;
  localparam logic [4:0] BD_16 = 5'd16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_COLOR_TYPE   = 2'd0,
    REG_BIT_DEPTH    = 2'd1,
    REG_PALETTE_SIZE = 2'd2,
    REG_ALPHA_COUNT  = 2'd3
  } cfg_reg_t;

  // Item modes.
  localparam logic MODE_CONVERT   = 1'b0;
  localparam logic MODE_LOAD_ENTRY = 1'b1;

  function automatic logic legal_format(input logic [2:0] ct, input logic [4:0] bd);
    logic sub;
    logic full;
    logic ok;
    sub  = (bd == BD_1) || (bd == BD_2) || (bd == BD_4);
    full = (bd == BD_8) || (bd == BD_16);
    unique case (ct)
      CT_GRAY:                     ok = sub || full;
      CT_PALETTE:                  ok = sub || (bd == BD_8);
      CT_RGB, CT_GRAY_ALPHA, CT_RGBA: ok = full;
      default:                     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### rtl/png_pixel_to_argb_converter_core.sv
// PNG pixel to ARGB8888 converter. An accepted pixel passes through the stage 1
// registers and then the output register onto argb. Throughput: one beat per cycle
// while the output is not stalled. Reset clears the registers to colour type 0,
// depth 8, empty palette and alpha counts; palette contents are not cleared and
// hold whatever was last written.
// Depends on p2argb_pkg and png_pixel_to_argb_converter_core_defines.svh.
`include "png_pixel_to_argb_converter_core_defines.svh"

module png_pixel_to_argb_converter_core
  import p2argb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [63:0]         pixel_bytes,
  input  logic [2:0]          sub_position,
  input  logic [7:0]          entry_index,
  input  logic [23:0]         entry_rgb,
  input  logic [7:0]          entry_alpha,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         argb
);

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DepthLimit = 9'(PALETTE_DEPTH);

  // Configuration registers.
  logic [2:0] pixel_type;
  logic [4:0] sample_bits;
  logic [8:0] palette_size;
  logic [8:0] alpha_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_type   <= CT_GRAY;
      sample_bits  <= BD_8;
      palette_size <= '0;
      alpha_count  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLOR_TYPE:   pixel_type   <= cfg_data[2:0];
        REG_BIT_DEPTH:    sample_bits  <= cfg_data[4:0];
        REG_PALETTE_SIZE: palette_size <= cfg_data;
        REG_ALPHA_COUNT:  alpha_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline has two stages: stage 1 holds a pixel whose palette read is in
  // flight, and the output register holds the finished word until it is taken.
  // Stage 1 moves on whenever the output register is empty or being drained, so
  // the input keeps flowing while a finished beat still waits downstream.
  logic s1_valid;
  logic s1_adv;
  logic s1_free;
  logic in_take;
  logic take_pixel;
  logic take_entry;

  assign s1_adv     = s1_valid && (!out_valid || !out_stall);
  assign s1_free    = !s1_valid || s1_adv;
  assign in_stall   = !s1_free;
  assign in_take    = in_valid && s1_free;
  assign take_pixel = in_take && (mode == MODE_CONVERT);
  assign take_entry = in_take && (mode == MODE_LOAD_ENTRY);

  // Pixel field extraction for sub-byte and 8-bit single-sample formats.
  logic [7:0] byte0;
  logic [7:0] sample;
  logic [7:0] gray_wide;

  assign byte0 = pixel_bytes[7:0];

  always_comb begin
    sample = byte0;
    unique case (sample_bits)
      BD_1: sample = {7'd0, byte0[3'd7 - sub_position]};
      BD_2: sample = {6'd0, 2'(byte0 >> {~sub_position[1:0], 1'b0})};
      BD_4: sample = {4'd0, (sub_position[0] ? byte0[3:0] : byte0[7:4])};
      default: sample = byte0;
    endcase
  end

  // Gray is widened by repeating the sample across the byte.
  always_comb begin
    unique case (sample_bits)
      BD_1:    gray_wide = {8{sample[0]}};
      BD_2:    gray_wide = {4{sample[1:0]}};
      BD_4:    gray_wide = {2{sample[3:0]}};
      default: gray_wide = sample;
    endcase
  end

  // Multi-byte formats: at 16 bits only the high byte of each sample is kept,
  // which lands on the even byte offsets.
  logic       has_color;
  logic       has_alpha;
  logic       deep;
  logic [7:0] byte_g;
  logic [7:0] byte_b;
  logic [7:0] byte_a;
  logic [7:0] wide_a;
  logic [7:0] wide_g;
  logic [7:0] wide_b;

  assign has_color = pixel_type[1];
  assign has_alpha = pixel_type[2];
  assign deep      = (sample_bits == BD_16);
  assign byte_g    = deep ? pixel_bytes[23:16] : pixel_bytes[15:8];
  assign byte_b    = deep ? pixel_bytes[39:32] : pixel_bytes[23:16];
  assign byte_a    = has_color ? (deep ? pixel_bytes[55:48] : pixel_bytes[31:24])
                               : byte_g;
  assign wide_a    = has_alpha ? byte_a : 8'hFF;
  assign wide_g    = has_color ? byte_g : byte0;
  assign wide_b    = has_color ? byte_b : byte0;

  logic        legal;
  logic        single_sample;
  logic        use_palette;
  logic [31:0] direct_word;

  assign legal         = legal_format(pixel_type, sample_bits);
  assign single_sample = !deep && ((pixel_type == CT_GRAY) || (pixel_type == CT_PALETTE));
  assign use_palette   = legal && single_sample && (pixel_type == CT_PALETTE);

  always_comb begin
    priority if (!legal) begin
      direct_word = '0;
    end else if (single_sample) begin
      direct_word = {8'hFF, gray_wide, gray_wide, gray_wide};
    end else begin
      direct_word = {wide_a, byte0, wide_g, wide_b};
    end
  end

  // Palette range checks, made before the read so that stage 1 only selects.
  logic [8:0] pal_index;
  logic       in_depth;
  logic       rgb_ok;
  logic       alpha_ok;

  assign pal_index = {1'b0, sample};
  assign in_depth  = pal_index < DepthLimit;
  assign rgb_ok    = in_depth && (pal_index < palette_size);
  assign alpha_ok  = in_depth && (pal_index < alpha_count);

  // Palette memories: one write port for entry loads, one registered read port
  // for lookups. A load and a lookup are never accepted on the same edge, and a
  // load is in the array before any later lookup reads it, so no bypass is needed.
  logic [23:0] pal_rgb_mem   [PALETTE_DEPTH];
  logic [7:0]  pal_alpha_mem [PALETTE_DEPTH];
  logic [23:0] pal_rd_rgb;
  logic [7:0]  pal_rd_alpha;
  logic        entry_in_depth;

  assign entry_in_depth = {1'b0, entry_index} < DepthLimit;

  always_ff @(posedge clk) begin
    if (take_entry && entry_in_depth) begin
      pal_rgb_mem[entry_index[IdxW-1:0]]   <= entry_rgb;
      pal_alpha_mem[entry_index[IdxW-1:0]] <= entry_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pixel) begin
      pal_rd_rgb   <= pal_rgb_mem[sample[IdxW-1:0]];
      pal_rd_alpha <= pal_alpha_mem[sample[IdxW-1:0]];
    end
  end

  // Stage 1 registers.
  logic        s1_valid_next;
  logic        s1_use_palette;
  logic        s1_rgb_ok;
  logic        s1_alpha_ok;
  logic [31:0] s1_direct;

  assign s1_valid_next = take_pixel ? 1'b1 : (s1_adv ? 1'b0 : s1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pixel) begin
      s1_use_palette <= use_palette;
      s1_rgb_ok      <= rgb_ok;
      s1_alpha_ok    <= alpha_ok;
      s1_direct      <= direct_word;
    end
  end

  // Palette result: black outside the colour count, opaque outside the alpha count.
  logic [31:0] s1_word;

  always_comb begin
    if (s1_use_palette) begin
      s1_word = {(s1_alpha_ok ? pal_rd_alpha : 8'hFF),
                 (s1_rgb_ok ? pal_rd_rgb : 24'd0)};
    end else begin
      s1_word = s1_direct;
    end
  end

  // Output register.
  logic out_valid_next;

  assign out_valid_next = s1_adv ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      argb <= s1_word;
    end
  end

  // A palette load never occupies stage 1.
  `P2A_CHECK_NEXT(a_load_no_result, take_entry, !s1_valid)
  // The input is only held off while stage 1 is full.
  `P2A_CHECK_NOW(a_stall_needs_s1, in_stall, s1_valid)
  // A blocked stage 1 keeps its pixel.
  `P2A_CHECK_NEXT(a_s1_holds, s1_valid && out_valid && out_stall, s1_valid && $stable(s1_direct))

endmodule
